// ===== rtl/crrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crrm_pkg
// shared constants, register map and payload types of the compression
// ratio reset monitor
// ----------------------------------------------------------------------------
package crrm_pkg;

    localparam int COUNT_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int RATIO_BITS   = FRAC_BITS + 3;
    localparam int GAIN_BITS    = (FRAC_BITS < 16) ? FRAC_BITS : 16;
    localparam int PAGES_BITS   = 7;
    localparam int DIV_CNT_BITS = $clog2(RATIO_BITS + 1);
    localparam int PROD_BITS    = RATIO_BITS + GAIN_BITS;
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;
    localparam int INDEX_BITS   = 3;

    localparam logic [PAGES_BITS-1:0] PAGES_MAX = {PAGES_BITS{1'b1}};

    localparam int SLOW_GAIN_INIT   = ((1 << FRAC_BITS) + 1000) / 2000;
    localparam int FAST_GAIN_INIT   = ((1 << FRAC_BITS) + 10) / 20;
    localparam int RATIO_LIMIT_INIT = (4 * (1 << FRAC_BITS) + 2) / 5;
    localparam int WARMUP_INIT      = 64;

    localparam logic [INDEX_BITS-1:0] REG_RESET_ENABLE = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_SLOW_GAIN    = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_FAST_GAIN    = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_RATIO_LIMIT  = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_WARMUP_PAGES = 3'd4;

    typedef struct packed {
        logic [COUNT_BITS-1:0] bytes_in_total;
        logic [COUNT_BITS-1:0] bytes_out_total;
    } in_t;

    typedef struct packed {
        logic [RATIO_BITS-1:0] page_ratio;
        logic [RATIO_BITS-1:0] slow_average;
        logic [RATIO_BITS-1:0] fast_average;
        logic                  clear_request;
    } out_t;

    typedef struct packed {
        logic                  reset_enable;
        logic [GAIN_BITS-1:0]  slow_gain;
        logic [GAIN_BITS-1:0]  fast_gain;
        logic [RATIO_BITS-1:0] ratio_limit;
        logic [PAGES_BITS-1:0] warmup_pages;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/crrm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crrm_front
// input side: takes page totals and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module crrm_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire crrm_pkg::in_t s_data,
    output logic               q_valid,
    output crrm_pkg::in_t      q_data,
    input  wire logic          q_pop
);
    import crrm_pkg::*;

    in_t        mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/crrm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crrm_div
// radix-2 restoring divider for the page ratio, one quotient bit a cycle,
// saturating when the integer part would exceed three bits
// ----------------------------------------------------------------------------
module crrm_div (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic [crrm_pkg::COUNT_BITS-1:0]      num,
    input  wire logic [crrm_pkg::COUNT_BITS-1:0]      den,
    output crrm_pkg::div_stat_t                       stat,
    output logic [crrm_pkg::RATIO_BITS-1:0]           quo
);
    import crrm_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS+2:0]   rem_reg;
    logic [COUNT_BITS+2:0]   dvs_reg;
    logic [RATIO_BITS-1:0]   quo_reg;
    logic                    sat_reg;

    logic [COUNT_BITS+3:0]   shifted;
    logic [COUNT_BITS+3:0]   diff;
    logic                    ge;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = sat_reg ? {RATIO_BITS{1'b1}} : quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {3'b000, num};
            dvs_reg <= {den, 3'b000};
            sat_reg <= ({3'b000, num} >= {den, 3'b000});
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[COUNT_BITS+2:0] : shifted[COUNT_BITS+2:0];
            quo_reg <= {quo_reg[RATIO_BITS-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_BITS'(RATIO_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/crrm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crrm_back
// per-page sequencer: page counts, ratio, slow and fast averages, clear
// decision and the result register
// ----------------------------------------------------------------------------
module crrm_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire crrm_pkg::cfg_t                  cfg,
    input  wire logic                            q_valid,
    input  wire crrm_pkg::in_t                   q_data,
    output logic                                 q_pop,
    output logic                                 div_start,
    output logic [crrm_pkg::COUNT_BITS-1:0]      div_num,
    output logic [crrm_pkg::COUNT_BITS-1:0]      div_den,
    input  wire crrm_pkg::div_stat_t             div_stat,
    input  wire logic [crrm_pkg::RATIO_BITS-1:0] div_quo,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output crrm_pkg::out_t                       m_data
);
    import crrm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    state_t                state_reg;
    state_t                state_next;

    logic [COUNT_BITS-1:0] prev_in_reg;
    logic [COUNT_BITS-1:0] prev_out_reg;
    logic [RATIO_BITS-1:0] slow_avg_reg;
    logic [RATIO_BITS-1:0] fast_avg_reg;
    logic [PAGES_BITS-1:0] pages_reg;
    logic [RATIO_BITS-1:0] ratio_reg;
    logic [RATIO_BITS-1:0] slow_diff_reg;
    logic [RATIO_BITS-1:0] fast_diff_reg;
    logic                  slow_up_reg;
    logic                  fast_up_reg;
    logic [PROD_BITS-1:0]  slow_prod_reg;
    logic [PROD_BITS-1:0]  fast_prod_reg;
    logic                  m_valid_reg;
    out_t                  m_data_reg;

    logic                  slot_free;
    logic                  commit;
    logic                  warm;
    logic [RATIO_BITS-1:0] slow_delta;
    logic [RATIO_BITS-1:0] fast_delta;
    logic [RATIO_BITS-1:0] slow_new;
    logic [RATIO_BITS-1:0] fast_new;
    logic [RATIO_BITS+1:0] slow_x3;
    logic [RATIO_BITS+1:0] fast_x2;
    logic                  clear;

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign div_start = q_pop;
    assign div_den   = q_data.bytes_in_total - prev_in_reg;
    assign div_num   = q_data.bytes_out_total - prev_out_reg;

    assign slot_free = !m_valid_reg || m_ready;
    assign commit    = (state_reg == ST_UPD) && slot_free;

    assign warm       = (pages_reg >= cfg.warmup_pages);
    assign slow_delta = slow_prod_reg[FRAC_BITS +: RATIO_BITS];
    assign fast_delta = fast_prod_reg[FRAC_BITS +: RATIO_BITS];
    assign slow_new   = !warm ? ratio_reg
                      : (slow_up_reg ? slow_avg_reg + slow_delta : slow_avg_reg - slow_delta);
    assign fast_new   = !warm ? ratio_reg
                      : (fast_up_reg ? fast_avg_reg + fast_delta : fast_avg_reg - fast_delta);
    assign slow_x3    = {2'b00, slow_new} + {1'b0, slow_new, 1'b0};
    assign fast_x2    = {1'b0, fast_new, 1'b0};
    assign clear      = cfg.reset_enable && warm
                        && ((slow_x3 < fast_x2) || (ratio_reg > cfg.ratio_limit));

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV && div_stat.done) begin
            ratio_reg     <= div_quo;
            slow_up_reg   <= (div_quo >= slow_avg_reg);
            fast_up_reg   <= (div_quo >= fast_avg_reg);
            slow_diff_reg <= (div_quo >= slow_avg_reg) ? div_quo - slow_avg_reg
                                                        : slow_avg_reg - div_quo;
            fast_diff_reg <= (div_quo >= fast_avg_reg) ? div_quo - fast_avg_reg
                                                        : fast_avg_reg - div_quo;
        end
        if (state_reg == ST_MUL) begin
            slow_prod_reg <= PROD_BITS'(slow_diff_reg) * PROD_BITS'(cfg.slow_gain);
            fast_prod_reg <= PROD_BITS'(fast_diff_reg) * PROD_BITS'(cfg.fast_gain);
        end
        if (commit) begin
            m_data_reg.page_ratio    <= ratio_reg;
            m_data_reg.slow_average  <= slow_new;
            m_data_reg.fast_average  <= fast_new;
            m_data_reg.clear_request <= clear;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_in_reg  <= '0;
            prev_out_reg <= '0;
            slow_avg_reg <= '0;
            fast_avg_reg <= '0;
            pages_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                prev_in_reg  <= q_data.bytes_in_total;
                prev_out_reg <= q_data.bytes_out_total;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
                if (clear) begin
                    prev_in_reg  <= '0;
                    prev_out_reg <= '0;
                    slow_avg_reg <= '0;
                    fast_avg_reg <= '0;
                    pages_reg    <= '0;
                end else begin
                    slow_avg_reg <= slow_new;
                    fast_avg_reg <= fast_new;
                    if (pages_reg != PAGES_MAX) begin
                        pages_reg <= pages_reg + 1'b1;
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/compression_ratio_reset_monitor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compression_ratio_reset_monitor_unit
// per-page compression ratio monitor with slow and fast averages that
// requests a dictionary clear when the ratio degrades
// ----------------------------------------------------------------------------
// pages are processed one at a time: the bit-serial ratio divider
// (19 quotient bits), then the multiply step, then the update step, which
// waits for a free result register
// a two-entry input queue accepts beats while the result register waits
// reset: synchronous active-low aresetn; totals, averages and page count
// return to zero and the configuration registers to their default values
// ----------------------------------------------------------------------------
module compression_ratio_reset_monitor_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire crrm_pkg::in_t                      s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output crrm_pkg::out_t                          m_data,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [crrm_pkg::ADDR_BITS-1:0]     paddr,
    input  wire logic [crrm_pkg::DATA_BITS-1:0]     pwdata,
    output logic [crrm_pkg::DATA_BITS-1:0]          prdata,
    output logic                                    pready
);
    import crrm_pkg::*;

    cfg_t                  cfg_reg;
    logic [INDEX_BITS-1:0] reg_index;
    logic                  cfg_write;

    logic                  q_valid;
    in_t                   q_data;
    logic                  q_pop;
    logic                  div_start;
    logic [COUNT_BITS-1:0] div_num;
    logic [COUNT_BITS-1:0] div_den;
    div_stat_t             div_stat;
    logic [RATIO_BITS-1:0] div_quo;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_enable <= 1'b0;
            cfg_reg.slow_gain    <= GAIN_BITS'(SLOW_GAIN_INIT);
            cfg_reg.fast_gain    <= GAIN_BITS'(FAST_GAIN_INIT);
            cfg_reg.ratio_limit  <= RATIO_BITS'(RATIO_LIMIT_INIT);
            cfg_reg.warmup_pages <= PAGES_BITS'(WARMUP_INIT);
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_RESET_ENABLE: cfg_reg.reset_enable <= pwdata[0];
                REG_SLOW_GAIN:    cfg_reg.slow_gain    <= pwdata[GAIN_BITS-1:0];
                REG_FAST_GAIN:    cfg_reg.fast_gain    <= pwdata[GAIN_BITS-1:0];
                REG_RATIO_LIMIT:  cfg_reg.ratio_limit  <= pwdata[RATIO_BITS-1:0];
                REG_WARMUP_PAGES: cfg_reg.warmup_pages <= pwdata[PAGES_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_RESET_ENABLE: prdata = DATA_BITS'(cfg_reg.reset_enable);
            REG_SLOW_GAIN:    prdata = DATA_BITS'(cfg_reg.slow_gain);
            REG_FAST_GAIN:    prdata = DATA_BITS'(cfg_reg.fast_gain);
            REG_RATIO_LIMIT:  prdata = DATA_BITS'(cfg_reg.ratio_limit);
            REG_WARMUP_PAGES: prdata = DATA_BITS'(cfg_reg.warmup_pages);
            default:          prdata = '0;
        endcase
    end

    crrm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    crrm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    crrm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .div_start (div_start),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_stat  (div_stat),
        .div_quo   (div_quo),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    a_pop_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_clear_enabled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clear_request) |-> cfg_reg.reset_enable)
        else $error("clear requested while disabled");

    a_full_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("queue filled without an input beat");

endmodule
`default_nettype wire

// ===== tb/compression_ratio_reset_monitor_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compression_ratio_reset_monitor_unit_tb
// feeds running byte totals page by page into the ratio monitor, predicts
// each page ratio, both moving averages and the clear decision from an
// in-bench model of the block, and compares every result beat field by field
// with and without random source gaps and sink stalls across several register settings
// ----------------------------------------------------------------------------
module compression_ratio_reset_monitor_unit_tb;
    import crrm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_PAGES  = 125;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_t                  s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_t                 m_data;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    compression_ratio_reset_monitor_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // model of the block
    cfg_t                  cfg_m;
    logic [COUNT_BITS-1:0] last_in_total;
    logic [COUNT_BITS-1:0] last_out_total;
    logic [RATIO_BITS-1:0] slow_avg_m;
    logic [RATIO_BITS-1:0] fast_avg_m;
    logic [PAGES_BITS-1:0] pages_m;

    in_t  pages_to_send[$];
    out_t page_reports_due[$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic in_taken       = 1'b0;

    function automatic logic [RATIO_BITS-1:0] ratio_q3(logic [COUNT_BITS-1:0] num,
                                                       logic [COUNT_BITS-1:0] den);
        logic [63:0] q;
        if (den == '0) begin
            return '1;
        end
        q = (64'(num) << FRAC_BITS) / 64'(den);
        if ((q >> RATIO_BITS) != 0) begin
            return '1;
        end
        return q[RATIO_BITS-1:0];
    endfunction

    // truncated move toward the ratio, never overshooting it
    function automatic logic [RATIO_BITS-1:0] ema_move(logic [RATIO_BITS-1:0] avg,
                                                       logic [RATIO_BITS-1:0] ratio,
                                                       logic [GAIN_BITS-1:0]  gain);
        logic [63:0] delta;
        if (ratio >= avg) begin
            delta = (64'(ratio - avg) * 64'(gain)) >> FRAC_BITS;
            return avg + delta[RATIO_BITS-1:0];
        end
        delta = (64'(avg - ratio) * 64'(gain)) >> FRAC_BITS;
        return avg - delta[RATIO_BITS-1:0];
    endfunction

    function automatic out_t predict_page(in_t beat);
        logic [COUNT_BITS-1:0] pg_in;
        logic [COUNT_BITS-1:0] pg_out;
        logic [RATIO_BITS-1:0] ratio;
        logic                  warm;
        logic                  clr;
        out_t                  res;
        pg_in          = beat.bytes_in_total - last_in_total;
        pg_out         = beat.bytes_out_total - last_out_total;
        last_in_total  = beat.bytes_in_total;
        last_out_total = beat.bytes_out_total;
        ratio          = ratio_q3(pg_out, pg_in);
        warm           = pages_m >= cfg_m.warmup_pages;
        if (!warm) begin
            slow_avg_m = ratio;
            fast_avg_m = ratio;
        end else begin
            slow_avg_m = ema_move(slow_avg_m, ratio, cfg_m.slow_gain);
            fast_avg_m = ema_move(fast_avg_m, ratio, cfg_m.fast_gain);
        end
        if (pages_m != PAGES_MAX) begin
            pages_m = pages_m + 1'b1;
        end
        clr = cfg_m.reset_enable && warm &&
              ((32'(slow_avg_m) * 3 < 32'(fast_avg_m) * 2) || (ratio > cfg_m.ratio_limit));
        res.page_ratio    = ratio;
        res.slow_average  = slow_avg_m;
        res.fast_average  = fast_avg_m;
        res.clear_request = clr;
        if (clr) begin
            last_in_total  = '0;
            last_out_total = '0;
            slow_avg_m     = '0;
            fast_avg_m     = '0;
            pages_m        = '0;
        end
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // source side and sink ready
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_taken) begin
                if (pages_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pages_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // beat monitor and checker
    always @(posedge aclk) begin : monitor
        out_t want;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) begin
            page_reports_due.push_back(predict_page(s_data));
        end
        if (aresetn && m_valid && m_ready) begin
            if (page_reports_due.size() == 0) begin
                mismatch_count++;
                $error("result beat with no page outstanding");
            end else begin
                want = page_reports_due.pop_front();
                check_field("page_ratio", want.page_ratio, m_data.page_ratio);
                check_field("slow_average", want.slow_average, m_data.slow_average);
                check_field("fast_average", want.fast_average, m_data.fast_average);
                check_field("clear_request", want.clear_request, m_data.clear_request);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic apb_write(logic [INDEX_BITS-1:0] idx, logic [DATA_BITS-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RESET_ENABLE: cfg_m.reset_enable = value[0];
            REG_SLOW_GAIN:    cfg_m.slow_gain    = value[GAIN_BITS-1:0];
            REG_FAST_GAIN:    cfg_m.fast_gain    = value[GAIN_BITS-1:0];
            REG_RATIO_LIMIT:  cfg_m.ratio_limit  = value[RATIO_BITS-1:0];
            REG_WARMUP_PAGES: cfg_m.warmup_pages = value[PAGES_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_page(logic [COUNT_BITS-1:0] in_total,
                              logic [COUNT_BITS-1:0] out_total);
        in_t beat;
        beat.bytes_in_total  = in_total;
        beat.bytes_out_total = out_total;
        pages_to_send.push_back(beat);
    endtask

    task automatic wait_drained();
        while (pages_to_send.size() != 0 || s_valid || page_reports_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [COUNT_BITS-1:0] in_tot;
        logic [COUNT_BITS-1:0] out_tot;
        longint unsigned       comp;
        longint unsigned       pg;
        int                    sel;
        cfg_m.reset_enable = 1'b0;
        cfg_m.slow_gain    = GAIN_BITS'(SLOW_GAIN_INIT);
        cfg_m.fast_gain    = GAIN_BITS'(FAST_GAIN_INIT);
        cfg_m.ratio_limit  = RATIO_BITS'(RATIO_LIMIT_INIT);
        cfg_m.warmup_pages = PAGES_BITS'(WARMUP_INIT);
        last_in_total      = '0;
        last_out_total     = '0;
        slow_avg_m         = '0;
        fast_avg_m         = '0;
        pages_m            = '0;
        send_idle_pct      = 25;
        recv_stall_pct     = 68;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults: zero-read pages, wrap, saturation, bit patterns
        queue_page(32'd0, 32'd0);
        queue_page(32'd4096, 32'd2048);
        queue_page(32'd4096, 32'd2048);
        queue_page(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_page(32'd0, 32'd0);
        queue_page(32'd100, 32'd900);
        queue_page(32'd200, 32'd1700);
        queue_page(32'd300, 32'd2499);
        queue_page(32'd301, 32'd2499);
        queue_page(32'd302, 32'd2500);
        queue_page(32'hAAAA_AAAA, 32'h5555_5555);
        queue_page(32'h5555_5555, 32'hAAAA_AAAA);
        wait_drained();

        // no warm-up, clear from the average test
        apb_write(REG_RESET_ENABLE, 32'd1);
        apb_write(REG_WARMUP_PAGES, 32'd0);
        apb_write(REG_SLOW_GAIN, 32'd0);
        apb_write(REG_FAST_GAIN, 32'd65535);
        apb_write(REG_RATIO_LIMIT, DATA_BITS'({RATIO_BITS{1'b1}}));
        queue_page(32'd1000, 32'd500);
        queue_page(32'd1000, 32'd500);
        wait_drained();

        // warm-up holds off the ratio limit
        apb_write(REG_SLOW_GAIN, 32'd65535);
        apb_write(REG_WARMUP_PAGES, 32'd3);
        apb_write(REG_RATIO_LIMIT, DATA_BITS'(RATIO_LIMIT_INIT));
        queue_page(32'd1000, 32'd900);
        queue_page(32'd2000, 32'd1800);
        queue_page(32'd3000, 32'd2700);
        queue_page(32'd4000, 32'd3600);
        wait_drained();

        // disabled: no clear above the limit
        apb_write(REG_RESET_ENABLE, 32'd0);
        apb_write(REG_WARMUP_PAGES, 32'd0);
        queue_page(32'd1000, 32'd1000);
        queue_page(32'd2000, 32'd2000);
        wait_drained();

        in_tot  = '0;
        out_tot = '0;
        comp    = 40000;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct  = 25;
                    recv_stall_pct = 68;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 25;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            apb_write(REG_RESET_ENABLE, (ph == 3) ? 32'd0 : 32'd1);
            apb_write(REG_SLOW_GAIN, (ph == 1) ? 32'd0 :
                                     (ph == 4) ? 32'd65535 : $urandom_range(0, 2000));
            apb_write(REG_FAST_GAIN, (ph == 1) ? 32'd65535 :
                                     (ph == 4) ? 32'd0 : $urandom_range(1000, 20000));
            apb_write(REG_RATIO_LIMIT, (ph == 2) ? DATA_BITS'({RATIO_BITS{1'b1}}) :
                                       (ph == 5) ? 32'd0 : $urandom_range(40000, 80000));
            apb_write(REG_WARMUP_PAGES, (ph == 0) ? 32'd0 :
                                        (ph == 2) ? 32'd127 : $urandom_range(1, 12));
            for (int n = 0; n < PHASE_PAGES; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 4) begin
                    // coder restarts its block
                    in_tot  = $urandom_range(0, 4096);
                    out_tot = $urandom_range(0, 4096);
                end else if (sel < 12) begin
                    in_tot  = $urandom;
                    out_tot = $urandom;
                end else if (sel < 15) begin
                    out_tot = out_tot + $urandom_range(0, 4096);
                end else begin
                    if ($urandom_range(0, 29) == 0) begin
                        comp = $urandom_range(6554, 98304);
                    end
                    pg      = $urandom_range(1, 8192);
                    in_tot  = in_tot + COUNT_BITS'(pg);
                    out_tot = out_tot + COUNT_BITS'((pg * comp) >> FRAC_BITS)
                              + $urandom_range(0, 15);
                end
                queue_page(in_tot, out_tot);
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/crrm_pkg.sv
rtl/crrm_front.sv
rtl/crrm_div.sv
rtl/crrm_back.sv
rtl/compression_ratio_reset_monitor_unit.sv
tb/compression_ratio_reset_monitor_unit_tb.sv
